@@ rtl/tst_pkg.sv @@
// Shared types, codes and helpers for the transfer slot table.
package tst_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int SLOT_W      = 4;
  localparam int CMD_W       = 3;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int CNT_W       = 5;
  localparam int MASK_W      = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SIZE  = 3'd3,
    CMD_PROG  = 3'd4,
    CMD_QUERY = 3'd5
  } tst_cmd_t;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RESP
  } tst_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] value;
  } tst_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_id;
    logic [DATA_W-1:0]   bytes_done;
    logic [DATA_W-1:0]   total_bytes;
    logic                is_active;
    logic                stop_requested;
    logic [MASK_W-1:0]   active_mask;
  } tst_out_t;

  // sequencer -> table
  typedef struct packed {
    logic load;   // latch the incoming beat
    logic step;   // advance the scan pointer
    logic grant;  // take the probed slot
    logic full;   // scan exhausted
    logic exec;   // run a slot command
  } tst_ctl_t;

  // table -> sequencer
  typedef struct packed {
    logic n_zero;
    logic busy;   // probed slot is taken
    logic last;   // probe is the last of the scan
  } tst_sts_t;

  // next index with wrap at the slot count
  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] idx,
                                                 input logic [CNT_W-1:0]  n);
    logic [CNT_W-1:0] nxt;
    nxt = {1'b0, idx} + CNT_W'(1);
    return (nxt == n) ? '0 : nxt[SLOT_W-1:0];
  endfunction

  // active bits limited to the first n slots
  function automatic logic [MASK_W-1:0] limit_mask(input logic [MAX_SLOTS-1:0] act,
                                                   input logic [CNT_W-1:0]     n);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      m[i] = act[i] && (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

@@ rtl/transfer_slot_table_top.sv @@
// Top level of the transfer slot table: config register, sequencer and slot storage.
// A non-allocate beat is latched, executed and then held as the result; an allocate
//   beat is latched, then probes slots by the next-fit scan (1 to slots in use).
// One beat at a time; the next beat is taken the cycle after the result is accepted.
// Reset (rst_n, synchronous): slots clear, scan start goes to 0, slots_in_use to 16.
module transfer_slot_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tst_pkg::tst_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tst_pkg::tst_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [tst_pkg::CNT_W-1:0]        cfg_wdata
);
  import tst_pkg::*;

  logic [CNT_W-1:0] slots_in_use_r;
  tst_ctl_t         ctl;
  tst_sts_t         sts;
  logic             in_is_alloc;

  // slot count register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= CNT_W'(MAX_SLOTS);
    end else if (cfg_we) begin
      slots_in_use_r <= cfg_wdata;
    end
  end

  assign in_is_alloc = (in_data.cmd == CMD_ALLOC);

  // sequencer: idle -> scan (allocate) or exec -> hold result until taken
  tst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_is_alloc (in_is_alloc),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .ctl         (ctl)
  );

  // slot storage with the scan pointer and the progress adder
  tst_table u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .slots_in_use (slots_in_use_r),
    .in_data      (in_data),
    .ctl          (ctl),
    .sts          (sts),
    .out_data     (out_data)
  );

endmodule

@@ rtl/tst_ctrl.sv @@
// Command sequencer: accepts a beat, runs the scan or the slot command, holds the result.
module tst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_alloc,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tst_pkg::tst_sts_t sts,
  output tst_pkg::tst_ctl_t ctl
);
  import tst_pkg::*;

  tst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_is_alloc ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        if (sts.n_zero || !sts.busy || sts.last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_SCAN: begin
        if (sts.n_zero) begin
          ctl.full = 1'b1;
        end else if (!sts.busy) begin
          ctl.grant = 1'b1;
        end else if (sts.last) begin
          ctl.full = 1'b1;
        end else begin
          ctl.step = 1'b1;
        end
      end
      ST_EXEC: ctl.exec = 1'b1;
      ST_RESP: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/tst_table.sv @@
// Slot storage, scan pointer, shared progress adder and result register.
module tst_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tst_pkg::CNT_W-1:0] slots_in_use,
  input  tst_pkg::tst_in_t          in_data,
  input  tst_pkg::tst_ctl_t         ctl,
  output tst_pkg::tst_sts_t         sts,
  output tst_pkg::tst_out_t         out_data
);
  import tst_pkg::*;

  logic [MAX_SLOTS-1:0] active_r;
  logic [MAX_SLOTS-1:0] stop_r;
  logic [DATA_W-1:0]    bytes_r [MAX_SLOTS];
  logic [DATA_W-1:0]    total_r [MAX_SLOTS];
  logic [SLOT_W-1:0]    next_start_r;

  logic [CMD_W-1:0]     cmd_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [DATA_W-1:0]    value_r;
  logic [SLOT_W-1:0]    scan_idx_r;
  logic [CNT_W-1:0]     scan_cnt_r;
  tst_out_t             res_r, res_nxt;

  logic [CNT_W-1:0]     n;
  logic [SLOT_W-1:0]    start;
  logic                 bad;
  logic                 act_nxt, stop_nxt;
  logic [DATA_W-1:0]    bytes_nxt, total_nxt;
  logic [MAX_SLOTS-1:0] active_upd;

  assign n     = (slots_in_use > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slots_in_use;
  assign start = ({1'b0, next_start_r} < n) ? next_start_r : '0;
  assign bad   = ({1'b0, slot_r} >= n);

  assign sts.n_zero = (n == '0);
  assign sts.busy   = active_r[scan_idx_r];
  assign sts.last   = (scan_cnt_r == n - CNT_W'(1));

  // new contents of the named slot
  always_comb begin
    act_nxt   = active_r[slot_r];
    stop_nxt  = stop_r[slot_r];
    bytes_nxt = bytes_r[slot_r];
    total_nxt = total_r[slot_r];
    case (cmd_r)
      CMD_FREE: begin
        act_nxt   = 1'b0;
        stop_nxt  = 1'b0;
        bytes_nxt = '0;
        total_nxt = '0;
      end
      CMD_STOP: stop_nxt  = 1'b1;
      CMD_SIZE: total_nxt = value_r;
      CMD_PROG: bytes_nxt = bytes_r[slot_r] + value_r;
      default: ;
    endcase
  end

  always_comb begin
    active_upd = active_r;
    if (ctl.grant) begin
      active_upd[scan_idx_r] = 1'b1;
    end else if (ctl.exec && !bad) begin
      active_upd[slot_r] = act_nxt;
    end
  end

  always_comb begin
    res_nxt             = '0;
    res_nxt.active_mask = limit_mask(active_upd, n);
    if (ctl.grant) begin
      res_nxt.status      = STAT_OK;
      res_nxt.slot_id     = scan_idx_r;
      res_nxt.bytes_done  = bytes_r[scan_idx_r];
      res_nxt.total_bytes = total_r[scan_idx_r];
      res_nxt.is_active   = 1'b1;
    end else if (ctl.full) begin
      res_nxt.status = STAT_FULL;
    end else if (bad) begin
      res_nxt.status  = STAT_BAD;
      res_nxt.slot_id = slot_r;
    end else begin
      res_nxt.status         = STAT_OK;
      res_nxt.slot_id        = slot_r;
      res_nxt.bytes_done     = bytes_nxt;
      res_nxt.total_bytes    = total_nxt;
      res_nxt.is_active      = act_nxt;
      res_nxt.stop_requested = stop_nxt;
    end
  end

  // slot state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= '0;
      stop_r       <= '0;
      next_start_r <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        bytes_r[i] <= '0;
        total_r[i] <= '0;
      end
    end else begin
      active_r <= active_upd;
      if (ctl.grant) begin
        stop_r[scan_idx_r] <= 1'b0;
        next_start_r       <= wrap_inc(scan_idx_r, n);
      end else if (ctl.exec && !bad) begin
        stop_r[slot_r]  <= stop_nxt;
        bytes_r[slot_r] <= bytes_nxt;
        total_r[slot_r] <= total_nxt;
      end
    end
  end

  // beat capture, scan pointer, result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= in_data.cmd;
      slot_r     <= in_data.slot;
      value_r    <= in_data.value;
      scan_idx_r <= start;
      scan_cnt_r <= '0;
    end else if (ctl.step) begin
      scan_idx_r <= wrap_inc(scan_idx_r, n);
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
    end
    if (ctl.grant || ctl.full || ctl.exec) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule

@@ tb/sv/transfer_slot_table_top_tb.sv @@
// Self-checking testbench for the transfer slot table: directed and random command traffic.
module transfer_slot_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tst_pkg::*;

  // Command codes outside the enum; the block treats both as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // The watchdog limit is many times the slowest legal run.
  localparam longint WATCHDOG_NS = 64'd20_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  tst_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  tst_out_t             out_data;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_wdata;

  transfer_slot_table_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the slot table, advanced once per accepted input beat.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]  cfg_slots = 5'd16;
  logic              slot_act   [MAX_SLOTS] = '{default: 1'b0};
  logic              slot_stop  [MAX_SLOTS] = '{default: 1'b0};
  logic [DATA_W-1:0] slot_bytes [MAX_SLOTS] = '{default: '0};
  logic [DATA_W-1:0] slot_total [MAX_SLOTS] = '{default: '0};
  logic [SLOT_W-1:0] next_start = '0;

  tst_out_t pending_results[$];

  // Idle knobs: gap_on lets the sender pause, stall_on lets the sink stall.
  bit gap_on;
  bit stall_on;

  int n_mismatch;
  int n_beats;
  int n_results;
  int n_full;
  int n_bad;

  // Slot count the table actually uses; zero means no slots at all.
  function automatic int eff_slots();
    return (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : int'(cfg_slots);
  endfunction

  // Apply one command to the shadow table and return the beat it should produce.
  function automatic tst_out_t apply_slot_cmd(tst_in_t b);
    tst_out_t r;
    int       n;
    int       first;
    int       idx;
    logic     found;
    logic     show;
    n = eff_slots();
    r = '0;
    r.status = STAT_OK;
    r.slot_id = b.slot;
    show = 1'b1;
    if (b.cmd == CMD_ALLOC) begin
      // next-fit: resume after the last grant, restart at 0 if past the end
      first = (next_start < n) ? int'(next_start) : 0;
      found = 1'b0;
      for (int k = 0; k < n && !found; k++) begin
        idx = (first + k) % n;
        if (!slot_act[idx]) begin
          slot_act[idx]  = 1'b1;
          slot_stop[idx] = 1'b0;
          next_start     = SLOT_W'((idx + 1) % n);
          r.slot_id      = SLOT_W'(idx);
          found          = 1'b1;
        end
      end
      if (!found) begin
        r.status  = STAT_FULL;
        r.slot_id = '0;
        show      = 1'b0;
      end
    end else if (b.slot >= n) begin
      r.status = STAT_BAD;
      show     = 1'b0;
    end else begin
      // inactive slots are acted on all the same
      case (b.cmd)
        CMD_FREE: begin
          slot_act[b.slot]   = 1'b0;
          slot_stop[b.slot]  = 1'b0;
          slot_bytes[b.slot] = '0;
          slot_total[b.slot] = '0;
        end
        CMD_STOP: slot_stop[b.slot] = 1'b1;
        CMD_SIZE: slot_total[b.slot] = b.value;
        CMD_PROG: slot_bytes[b.slot] = slot_bytes[b.slot] + b.value;
        default: ;
      endcase
    end
    if (show) begin
      r.bytes_done     = slot_bytes[r.slot_id];
      r.total_bytes    = slot_total[r.slot_id];
      r.is_active      = slot_act[r.slot_id];
      r.stop_requested = slot_stop[r.slot_id];
    end
    // only slots below the count show in the mask
    for (int i = 0; i < n; i++) r.active_mask[i] = slot_act[i];
    return r;
  endfunction

  // Mostly no pause, sometimes a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      n_mismatch++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Result checker and input monitor, both sampled on the rising edge.
  // The result side runs first; a result never shares an edge with the
  // beat that caused it, since a scan or exec state lies between them.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    tst_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat, expected none, got %0h", $time, out_data);
          n_mismatch++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_data.status));
          check_field("slot_id", DATA_W'(want.slot_id), DATA_W'(out_data.slot_id));
          check_field("bytes_done", want.bytes_done, out_data.bytes_done);
          check_field("total_bytes", want.total_bytes, out_data.total_bytes);
          check_field("is_active", DATA_W'(want.is_active), DATA_W'(out_data.is_active));
          check_field("stop_requested", DATA_W'(want.stop_requested),
                      DATA_W'(out_data.stop_requested));
          check_field("active_mask", DATA_W'(want.active_mask),
                      DATA_W'(out_data.active_mask));
          case (want.status)
            STAT_FULL: n_full++;
            STAT_BAD:  n_bad++;
            default:   ;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        want = apply_slot_cmd(in_data);
        pending_results = {pending_results, want};
      end
    end
  end

  // Sink side: random stalls on out_ready while stall_on is set.
  initial begin : sink_stall
    int hold;
    out_ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (stall_on) hold = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving helpers. Every task is entered and left on a falling edge.
  // ---------------------------------------------------------------------

  // Send one beat; valid stays high after acceptance so back-to-back beats
  // never drop and re-raise it in the same step.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [DATA_W-1:0] value);
    int gap;
    gap = gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.cmd   <= cmd;
    in_data.slot  <= slot;
    in_data.value <= value;
    do @(posedge clk); while (!in_ready);
    n_beats++;
    @(negedge clk);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic set_slot_count(input logic [CNT_W-1:0] count);
    wait_results_done();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_slots = count;
  endtask

  // Random command, biased toward live slots so sequences go deep.
  task automatic send_random_beat();
    int                live[$];
    int                pick;
    int                n;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] value;
    n = eff_slots();
    for (int i = 0; i < n; i++) if (slot_act[i]) live = {live, i};
    pick = $urandom_range(0, 99);
    if (pick < 18)      cmd = CMD_ALLOC;
    else if (pick < 33) cmd = CMD_FREE;
    else if (pick < 41) cmd = CMD_STOP;
    else if (pick < 54) cmd = CMD_SIZE;
    else if (pick < 83) cmd = CMD_PROG;
    else if (pick < 96) cmd = CMD_QUERY;
    else if (pick < 98) cmd = CMD_SPARE6;
    else                cmd = CMD_SPARE7;
    if (live.size() != 0 && $urandom_range(0, 3) != 0)
      slot = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    else
      slot = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
    // progress is mostly small steps, sometimes large enough to wrap
    pick = $urandom_range(0, 9);
    if (cmd == CMD_PROG && pick < 6) value = $urandom_range(0, 4095);
    else if (pick < 8)               value = $urandom;
    else                             value = 32'hFFFF_FFFF - $urandom_range(0, 255);
    send_beat(cmd, slot, value);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Full table at its reset size: grants, wrap of the byte count, stop,
  // work on an inactive slot, double free, next-fit order, spare codes.
  task automatic test_directed_full_table();
    gap_on   = 1'b1;
    stall_on = 1'b1;
    send_beat(CMD_QUERY, 4'd15, 32'h0);
    send_beat(CMD_ALLOC, 4'd9, 32'hFFFF_FFFF);
    send_beat(CMD_ALLOC, 4'd0, 32'h0);
    send_beat(CMD_ALLOC, 4'd15, 32'h0);
    send_beat(CMD_SIZE, 4'd1, 32'hFFFF_FFFF);
    send_beat(CMD_PROG, 4'd1, 32'hFFFF_FFF0);
    send_beat(CMD_PROG, 4'd1, 32'h0000_0020);
    send_beat(CMD_STOP, 4'd1, 32'h0);
    send_beat(CMD_PROG, 4'd9, 32'h0000_0005);
    send_beat(CMD_FREE, 4'd1, 32'h0);
    send_beat(CMD_FREE, 4'd1, 32'h0);
    // next-fit: slot 3, not the freed slot 1
    send_beat(CMD_ALLOC, 4'd0, 32'h0);
    send_beat(CMD_SPARE6, 4'd0, 32'h0);
    send_beat(CMD_SPARE7, 4'd9, 32'h0);
  endtask

  // Small, empty and oversized tables: bad slots, restart of the search at
  // slot 0, a full table, and a count above 16 clamped back to 16.
  task automatic test_directed_sizes();
    set_slot_count(5'd3);
    send_beat(CMD_QUERY, 4'd3, 32'h0);
    send_beat(CMD_SIZE, 4'd15, 32'h1234_5678);
    send_beat(CMD_ALLOC, 4'd0, 32'h0);
    send_beat(CMD_ALLOC, 4'd0, 32'h0);
    set_slot_count(5'd0);
    send_beat(CMD_ALLOC, 4'd0, 32'h0);
    send_beat(CMD_QUERY, 4'd0, 32'h0);
    set_slot_count(5'd31);
    send_beat(CMD_QUERY, 4'd15, 32'h0);
    send_beat(CMD_PROG, 4'd3, 32'h8000_0000);
  endtask

  // Random traffic over a series of table sizes, extremes included.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] sizes[11];
    sizes = '{5'd16, 5'd1, 5'd2, 5'd16, 5'd5, 5'd8, 5'd1, 5'd12, 5'd16, 5'd3, 5'd0};
    sizes[10] = CNT_W'($urandom_range(1, 16));
    foreach (sizes[p]) begin
      set_slot_count(sizes[p]);
      // some phases run with no idling on one side or both
      gap_on   = (p % 3 != 2);
      stall_on = (p % 4 != 3);
      repeat (90) send_random_beat();
    end
  endtask

  // Back-to-back bursts with the sender held until the table has answered all.
  task automatic test_burst_and_drain();
    set_slot_count(5'd16);
    gap_on   = 1'b0;
    stall_on = 1'b1;
    repeat (50) send_random_beat();
    wait_results_done();
    stall_on = 1'b0;
    repeat (50) send_random_beat();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    gap_on    = 1'b0;
    stall_on  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_full_table();
    test_directed_sizes();
    test_random_traffic();
    test_burst_and_drain();

    // let the last results land, then allow for the longest scan
    wait_results_done();
    repeat (40) @(negedge clk);

    $display("Sent %0d command beats over table sizes 0 to 31, checked %0d results.",
             n_beats, n_results);
    $display("Results: %0d table full, %0d bad slot, %0d mismatches.",
             n_full, n_bad, n_mismatch);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tst_pkg.sv
rtl/tst_ctrl.sv
rtl/tst_table.sv
rtl/transfer_slot_table_top.sv
tb/sv/transfer_slot_table_top_tb.sv
